// ----- src/fdsf_pkg.sv -----
// ----------------------------------------------------------------------------
// fdsf_pkg: shared types and constants of the frame difference span finder
// Holds the transaction structs, register codes, field widths and the
// register clamp function used by the configuration registers.
// ----------------------------------------------------------------------------
package fdsf_pkg;

  localparam int CFG_W          = 11;
  localparam int PIXEL_WORD_W   = 32;
  localparam int BYTE_W         = 8;
  localparam int BYTES_PER_WORD = 4;
  localparam int LANE_W         = $clog2(BYTES_PER_WORD);
  localparam int SPAN_X_W       = 10;
  localparam int SPAN_Y_W       = 10;
  localparam int SPAN_LEN_W     = 11;

  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_HEIGHT   = 1024;
  localparam int RST_FRAME_WIDTH  = 240;
  localparam int RST_FRAME_HEIGHT = 320;

  // Register indexes of the configuration port.
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIXEL_WORD_W-1:0] new_pixels;
    logic [PIXEL_WORD_W-1:0] old_pixels;
  } word_t;

  typedef struct packed {
    logic                  span_valid;
    logic [SPAN_X_W-1:0]   span_x;
    logic [SPAN_Y_W-1:0]   span_y;
    logic [SPAN_LEN_W-1:0] span_len;
    logic                  frame_end;
  } span_t;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } frame_cfg_t;

  // Differing pixels of one word: any, leftmost and rightmost lane.
  typedef struct packed {
    logic              any;
    logic [LANE_W-1:0] first;
    logic [LANE_W-1:0] last;
  } diff_t;

  // A zero register acts as one, anything above the maximum as the maximum.
  function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v,
                                                 input int maxv);
    logic [CFG_W-1:0] r;
    r = v;
    if (r == '0) begin
      r = CFG_W'(1);
    end
    if (int'(r) > maxv) begin
      r = CFG_W'(maxv);
    end
    return r;
  endfunction

endpackage

// ----- src/fdsf_cfg.sv -----
// ----------------------------------------------------------------------------
// fdsf_cfg: frame geometry registers
// Holds frame width and height, clamped to their legal range when written.
// ----------------------------------------------------------------------------
module fdsf_cfg #(
  parameter int MAX_WIDTH  = fdsf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdsf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [0:0]               cfg_index,
  input  logic [fdsf_pkg::CFG_W-1:0] cfg_data,
  output fdsf_pkg::frame_cfg_t     cfg
);
  import fdsf_pkg::*;

  localparam logic [CFG_W-1:0] RST_W = clamp_reg(CFG_W'(RST_FRAME_WIDTH), MAX_WIDTH);
  localparam logic [CFG_W-1:0] RST_H = clamp_reg(CFG_W'(RST_FRAME_HEIGHT), MAX_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= RST_W;
      cfg.height <= RST_H;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  cfg.width  <= clamp_reg(cfg_data, MAX_WIDTH);
        REG_FRAME_HEIGHT: cfg.height <= clamp_reg(cfg_data, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

endmodule

// ----- src/fdsf_cmp.sv -----
// ----------------------------------------------------------------------------
// fdsf_cmp: pixel compare of one word
// Compares the four byte lanes, masks pad pixels past the frame width and
// finds the leftmost and rightmost differing lane.
// ----------------------------------------------------------------------------
module fdsf_cmp #(
  parameter int MAX_WIDTH = fdsf_pkg::DEF_MAX_WIDTH
) (
  input  fdsf_pkg::word_t              word,
  input  logic [fdsf_pkg::CFG_W-1:0]   width,
  input  logic [$clog2(((MAX_WIDTH + 3) / 4) > 1 ? ((MAX_WIDTH + 3) / 4) : 2)-1:0] col,
  output fdsf_pkg::diff_t              diff
);
  import fdsf_pkg::*;

  localparam int WORDS_MAX = (MAX_WIDTH + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
  localparam int COL_W     = $clog2(WORDS_MAX > 1 ? WORDS_MAX : 2);
  localparam int PIX_W     = COL_W + LANE_W;
  localparam int CMP_W     = (PIX_W > CFG_W) ? PIX_W : CFG_W;

  logic [BYTES_PER_WORD-1:0] lane_diff;
  logic [PIX_W-1:0]          pix [BYTES_PER_WORD];

  always_comb begin
    for (int b = 0; b < BYTES_PER_WORD; b++) begin
      pix[b]       = {col, LANE_W'(b)};
      lane_diff[b] = (CMP_W'(pix[b]) < CMP_W'(width)) &&
                     (word.new_pixels[b*BYTE_W +: BYTE_W] !=
                      word.old_pixels[b*BYTE_W +: BYTE_W]);
    end
  end

  always_comb begin
    diff.any   = |lane_diff;
    diff.first = '0;
    diff.last  = '0;
    for (int b = BYTES_PER_WORD - 1; b >= 0; b--) begin
      if (lane_diff[b]) begin
        diff.first = LANE_W'(b);
      end
    end
    for (int b = 0; b < BYTES_PER_WORD; b++) begin
      if (lane_diff[b]) begin
        diff.last = LANE_W'(b);
      end
    end
  end

endmodule

// ----- src/fdsf_run.sv -----
// ----------------------------------------------------------------------------
// fdsf_run: raster position and run tracker
// Keeps the word column, the row and the open run, and forms the result
// for the word in the input register. State moves only when that word leaves.
// ----------------------------------------------------------------------------
module fdsf_run #(
  parameter int MAX_WIDTH  = fdsf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdsf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fdsf_pkg::frame_cfg_t cfg,
  input  fdsf_pkg::diff_t      diff,
  input  logic                 go,
  output logic [$clog2(((MAX_WIDTH + 3) / 4) > 1 ? ((MAX_WIDTH + 3) / 4) : 2)-1:0] col,
  output fdsf_pkg::span_t      res,
  output logic                 has_res
);
  import fdsf_pkg::*;

  localparam int WORDS_MAX = (MAX_WIDTH + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
  localparam int COL_W     = $clog2(WORDS_MAX > 1 ? WORDS_MAX : 2);
  localparam int PIX_W     = COL_W + LANE_W;
  localparam int ROW_W     = $clog2(MAX_HEIGHT > 1 ? MAX_HEIGHT : 2);
  localparam int SUM_W     = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
  localparam int RSUM_W    = ((ROW_W > CFG_W) ? ROW_W : CFG_W) + 1;

  logic [ROW_W-1:0] row;
  logic             in_run;
  logic [PIX_W-1:0] run_start;
  logic [PIX_W-1:0] run_last;

  logic [SUM_W-1:0] words;
  logic             row_end;
  logic             frame_last;
  logic             emit;
  logic [PIX_W-1:0] cur_start;
  logic [PIX_W-1:0] cur_last;
  logic [PIX_W:0]   len;

  always_comb begin
    words      = (SUM_W'(cfg.width) + SUM_W'(BYTES_PER_WORD - 1)) >> LANE_W;
    row_end    = (SUM_W'(col) + SUM_W'(1)) >= words;
    frame_last = row_end && ((RSUM_W'(row) + RSUM_W'(1)) >= RSUM_W'(cfg.height));
    cur_start  = in_run ? run_start : {col, diff.first};
    cur_last   = diff.any ? {col, diff.last} : run_last;
    // A run closes at a word with no change, or at the end of its row.
    emit       = diff.any ? row_end : in_run;
    len        = (PIX_W+1)'(cur_last) - (PIX_W+1)'(cur_start) + (PIX_W+1)'(1);
    has_res    = emit || frame_last;

    res.span_valid = emit;
    res.span_x     = emit ? SPAN_X_W'(cur_start) : '0;
    res.span_y     = emit ? SPAN_Y_W'(row) : '0;
    res.span_len   = emit ? SPAN_LEN_W'(len) : '0;
    res.frame_end  = frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      in_run    <= 1'b0;
      run_start <= '0;
      run_last  <= '0;
    end else if (go) begin
      if (row_end) begin
        col <= '0;
        row <= frame_last ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
      in_run <= !row_end && !emit && (in_run || diff.any);
      if (!in_run && diff.any) begin
        run_start <= {col, diff.first};
      end
      if (diff.any) begin
        run_last <= {col, diff.last};
      end
    end
  end

endmodule

// ----- src/frame_diff_span_finder.sv -----
// ----------------------------------------------------------------------------
// frame_diff_span_finder: changed span detection between two framebuffers
// Streams old and new frame words in raster order and reports each run of
// changed pixels in a row as x, y and length, plus a frame end marker.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   word      in         word_valid/word_stall    word_t   (new and old pixels)
//   result    out        result_valid/result_stall span_t  (span and frame end)
//   cfg       in         cfg_write               cfg_index, cfg_data
//
// Each word waits in the input register and its result, if any, is loaded
// into the result register when the word leaves.
// A new word is taken every cycle while no result is blocked; the single
// compare and run update between the input and result registers sets that rate.
// Reset is synchronous and active high; it restores width 240 and height 320
// (clamped to the maximums) and starts at column zero of row zero.
// A stalled result holds the result register; words that produce no result
// still drain from the input register while the output is stalled.
//
module frame_diff_span_finder #(
  parameter int MAX_WIDTH  = fdsf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdsf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       word_valid,
  output logic                       word_stall,
  input  fdsf_pkg::word_t            word,
  output logic                       result_valid,
  input  logic                       result_stall,
  output fdsf_pkg::span_t            result,
  input  logic                       cfg_write,
  input  logic [0:0]                 cfg_index,
  input  logic [fdsf_pkg::CFG_W-1:0] cfg_data
);
  import fdsf_pkg::*;

  localparam int WORDS_MAX = (MAX_WIDTH + BYTES_PER_WORD - 1) / BYTES_PER_WORD;
  localparam int COL_W     = $clog2(WORDS_MAX > 1 ? WORDS_MAX : 2);

  frame_cfg_t       cfg;
  diff_t            diff;
  span_t            res;
  logic             has_res;
  logic [COL_W-1:0] col;

  // Input register.
  logic  in_valid;
  word_t in_word;

  logic out_free;
  logic go;
  logic take;

  fdsf_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  fdsf_cmp #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_cmp (
    .word (in_word),
    .width(cfg.width),
    .col  (col),
    .diff (diff)
  );

  fdsf_run #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_run (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .diff   (diff),
    .go     (go),
    .col    (col),
    .res    (res),
    .has_res(has_res)
  );

  // The result register can load when it is empty or being emptied this cycle.
  // The held word leaves unless it has a result and that register is blocked.
  assign out_free   = !result_valid || !result_stall;
  assign go         = in_valid && (!has_res || out_free);
  assign word_stall = in_valid && !go;
  assign take       = word_valid && !word_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_word <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go && has_res) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && has_res) begin
      result <= res;
    end
  end

endmodule

// ----- src/fdsf_chk.sv -----
// ----------------------------------------------------------------------------
// fdsf_chk: port checker for the frame difference span finder
// Watches the result channel for stall behavior and result consistency, and
// the word channel for stalls while the block is free.
module fdsf_chk (
  input logic            clk,
  input logic            rst,
  input logic            word_valid,
  input logic            word_stall,
  input logic            result_valid,
  input logic            result_stall,
  input fdsf_pkg::span_t result
);
  import fdsf_pkg::*;

  // A stalled result transaction stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result transaction dropped while stalled");

  // A stalled result transaction keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result))
    else $error("result payload changed while stalled");

  // A result without a span only comes from the last word of a frame.
  a_empty_is_frame_end: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.span_valid |->
      result.frame_end && result.span_len == '0 &&
      result.span_x == '0 && result.span_y == '0)
    else $error("result without span outside frame end");

  // A reported span covers at least one pixel.
  a_span_nonempty: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.span_valid |-> result.span_len != '0)
    else $error("span of zero length");

  // The block never stalls words while both its registers are free.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    $past(!word_valid) && !result_valid |-> !word_stall)
    else $error("word stalled while block is empty");

endmodule

bind frame_diff_span_finder fdsf_chk u_fdsf_chk (
  .clk         (clk),
  .rst         (rst),
  .word_valid  (word_valid),
  .word_stall  (word_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);
